/* rtl/mtc_pkg.sv */
// Shared types and constants of the mixer traverse controller.
package mtc_pkg;

   localparam int unsigned HALF_MINUTE_MS = 30000;
   localparam int unsigned END_HIT_W      = 23;
   localparam int unsigned CNT_W          = 16;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_JOG_L_PRESS = 3'd1,
      OP_JOG_L_REL   = 3'd2,
      OP_JOG_R_PRESS = 3'd3,
      OP_JOG_R_REL   = 3'd4,
      OP_MIX_TOGGLE  = 3'd5,
      OP_SHUTDOWN    = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      DIR_LEFT      = 3'd0,
      DIR_HIT_LEFT  = 3'd1,
      DIR_RIGHT     = 3'd2,
      DIR_HIT_RIGHT = 3'd3,
      DIR_NONE      = 3'd4
   } dir_type;

   typedef enum logic [1:0] {
      REG_DWELL_HM      = 2'd0,
      REG_DEFAULT_DWELL = 2'd1,
      REG_START_DELAY   = 2'd2,
      REG_IMP_TIMEOUT   = 2'd3
   } reg_type;

   typedef struct packed {
      logic [7:0]           dwell_half_minutes;
      logic [END_HIT_W-1:0] dwell_scaled_ms;
      logic [CNT_W-1:0]     default_dwell_ms;
      logic [CNT_W-1:0]     start_delay_ms;
      logic [CNT_W-1:0]     impulse_timeout_ms;
   } cfg_type;

   typedef struct packed {
      dir_type              travel_dir;
      logic                 run_flag;
      logic                 left_drive;
      logic                 right_drive;
      logic                 auto_mix;
      logic                 error_latch;
      logic                 jog_held;
      logic                 impulse_prev;
      logic [END_HIT_W-1:0] since_end_hit;
      logic [CNT_W-1:0]     since_turn_on;
      logic [CNT_W-1:0]     since_impulse;
   } state_type;

   typedef struct packed {
      logic    drying_active;
      logic    left_end_n;
      logic    right_end_n;
      logic    impulse_level;
   } pins_type;

endpackage

/* rtl/mtc_step.sv */
// Next-state logic of the controller for one tick or command transaction.
module mtc_step (
   input  mtc_pkg::op_type    op,
   input  mtc_pkg::pins_type  pins,
   input  mtc_pkg::cfg_type   cfg,
   input  mtc_pkg::state_type cur,
   output mtc_pkg::state_type nxt
);
   import mtc_pkg::*;

   logic                 left_pressed;
   logic                 right_pressed;
   logic [END_HIT_W-1:0] dwell;
   logic                 delay_done;
   logic                 blocked;

   assign left_pressed  = ~pins.left_end_n;
   assign right_pressed = ~pins.right_end_n;
   assign dwell = (cfg.dwell_half_minutes == 8'd0) ?
                  END_HIT_W'(cfg.default_dwell_ms) : cfg.dwell_scaled_ms;

   always_comb begin
      nxt        = cur;
      delay_done = 1'b0;
      blocked    = 1'b0;
      case (op) inside
         OP_TICK: begin
            if (nxt.since_end_hit != '1) nxt.since_end_hit = nxt.since_end_hit + END_HIT_W'(1);
            if (nxt.since_turn_on != '1) nxt.since_turn_on = nxt.since_turn_on + CNT_W'(1);
            if (nxt.since_impulse != '1) nxt.since_impulse = nxt.since_impulse + CNT_W'(1);
            if (pins.drying_active && nxt.auto_mix && !nxt.error_latch &&
                dwell < nxt.since_end_hit) begin
               if (!nxt.run_flag) begin
                  nxt.run_flag      = 1'b1;
                  nxt.since_turn_on = '0;
                  nxt.since_impulse = '0;
               end
               if (nxt.travel_dir == DIR_HIT_RIGHT) begin
                  nxt.travel_dir = DIR_LEFT;
               end else if (nxt.travel_dir == DIR_HIT_LEFT ||
                            nxt.travel_dir == DIR_NONE) begin
                  nxt.travel_dir = DIR_RIGHT;
               end
            end
            delay_done = !(cfg.start_delay_ms > nxt.since_turn_on);
            if ((pins.drying_active || (nxt.jog_held && !nxt.error_latch)) && delay_done) begin
               if (nxt.travel_dir == DIR_LEFT && !left_pressed) begin
                  nxt.right_drive = 1'b0;
                  nxt.left_drive  = 1'b1;
               end else if (nxt.travel_dir == DIR_RIGHT && !right_pressed) begin
                  nxt.left_drive  = 1'b0;
                  nxt.right_drive = 1'b1;
               end
            end
            if (left_pressed && nxt.travel_dir == DIR_LEFT) begin
               nxt.left_drive    = 1'b0;
               nxt.since_end_hit = '0;
               nxt.travel_dir    = DIR_HIT_LEFT;
               if (!nxt.jog_held && !nxt.error_latch && cfg.dwell_half_minutes != 8'd0) begin
                  nxt.run_flag = 1'b0;
               end
            end
            if (right_pressed && nxt.travel_dir == DIR_RIGHT) begin
               nxt.right_drive   = 1'b0;
               nxt.since_end_hit = '0;
               nxt.travel_dir    = DIR_HIT_RIGHT;
               if (!nxt.jog_held && !nxt.error_latch && cfg.dwell_half_minutes != 8'd0) begin
                  nxt.run_flag = 1'b0;
               end
            end
            if (nxt.run_flag) begin
               if (pins.impulse_level != nxt.impulse_prev) begin
                  nxt.impulse_prev  = pins.impulse_level;
                  nxt.since_impulse = '0;
               end
               if (cfg.impulse_timeout_ms < nxt.since_impulse) begin
                  nxt.run_flag = 1'b0;
                  if (nxt.error_latch) begin
                     nxt.left_drive  = 1'b0;
                     nxt.right_drive = 1'b0;
                  end
                  nxt.error_latch = 1'b1;
               end
            end
         end
         OP_JOG_L_PRESS, OP_JOG_R_PRESS: begin
            blocked = (op == OP_JOG_L_PRESS) ? left_pressed : right_pressed;
            if (!blocked && !nxt.jog_held) begin
               if (nxt.error_latch) begin
                  nxt.run_flag    = 1'b0;
                  nxt.left_drive  = 1'b0;
                  nxt.right_drive = 1'b0;
               end else begin
                  nxt.run_flag      = 1'b1;
                  nxt.since_turn_on = '0;
                  nxt.since_impulse = '0;
               end
               nxt.travel_dir = (op == OP_JOG_L_PRESS) ? DIR_LEFT : DIR_RIGHT;
               nxt.jog_held   = 1'b1;
            end
         end
         OP_JOG_L_REL, OP_JOG_R_REL: begin
            if (op == OP_JOG_L_REL) nxt.left_drive = 1'b0;
            else nxt.right_drive = 1'b0;
            nxt.travel_dir = DIR_NONE;
            nxt.run_flag   = 1'b0;
            if (nxt.error_latch) begin
               nxt.left_drive  = 1'b0;
               nxt.right_drive = 1'b0;
            end
            nxt.jog_held = 1'b0;
         end
         OP_MIX_TOGGLE: begin
            if (nxt.error_latch || nxt.auto_mix) begin
               nxt.error_latch = 1'b0;
               nxt.auto_mix    = 1'b0;
               nxt.run_flag    = 1'b0;
               nxt.left_drive  = 1'b0;
               nxt.right_drive = 1'b0;
               nxt.travel_dir  = DIR_NONE;
            end else begin
               nxt.auto_mix = 1'b1;
            end
         end
         OP_SHUTDOWN: begin
            nxt.run_flag    = 1'b0;
            nxt.left_drive  = 1'b0;
            nxt.right_drive = 1'b0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

/* rtl/mixer_traverse_controller.sv */
// Top level of the mixer traverse controller: register port, state and result register.
// The result of a transaction is registered and is on rsp_tdata in the cycle after its acceptance.
// Throughput: one transaction per cycle while results are taken; the whole update is one pass through mtc_step.
// A result that is not taken holds the result register and stalls new requests.
// Reset (synchronous, active high) restores the registers to their defaults, clears the
// controller state with automatic mixing enabled and empties the result register.
module mixer_traverse_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: op[2:0], drying_active, left_end_n, right_end_n, impulse_level.
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: mixer_run, drive_left, drive_right, stall_error, travel_state[2:0].
   output logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mtc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic [7:0] rsp_data_in;
   logic       req_accept;
   logic       csr_write;
   reg_type    csr_sel;
   op_type     req_op;
   pins_type   req_pins;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = reg_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_DWELL_HM: begin
               cfg_in.dwell_half_minutes = csr_pwdata[7:0];
               cfg_in.dwell_scaled_ms = END_HIT_W'(csr_pwdata[7:0]) *
                                        END_HIT_W'(HALF_MINUTE_MS);
            end
            REG_DEFAULT_DWELL: cfg_in.default_dwell_ms   = csr_pwdata[15:0];
            REG_START_DELAY:   cfg_in.start_delay_ms     = csr_pwdata[15:0];
            REG_IMP_TIMEOUT:   cfg_in.impulse_timeout_ms = csr_pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_DWELL_HM:      csr_prdata = 32'(cfg_ff.dwell_half_minutes);
         REG_DEFAULT_DWELL: csr_prdata = 32'(cfg_ff.default_dwell_ms);
         REG_START_DELAY:   csr_prdata = 32'(cfg_ff.start_delay_ms);
         REG_IMP_TIMEOUT:   csr_prdata = 32'(cfg_ff.impulse_timeout_ms);
         default:           csr_prdata = '0;
      endcase
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tdata[2:0]);
   assign req_pins   = '{drying_active: req_tdata[3], left_end_n: req_tdata[4],
                         right_end_n: req_tdata[5], impulse_level: req_tdata[6]};

   mtc_step u_step (
      .op   (req_op),
      .pins (req_pins),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_in)
   );

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = req_accept ?
                         {1'b0, state_in.travel_dir, state_in.error_latch,
                          state_in.right_drive, state_in.left_drive, state_in.run_flag} :
                         rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{dwell_half_minutes: 8'd0, dwell_scaled_ms: '0,
                     default_dwell_ms: 16'd5000, start_delay_ms: 16'd2000,
                     impulse_timeout_ms: 16'd2000};
         state_ff <= '{travel_dir: DIR_NONE, run_flag: 1'b0, left_drive: 1'b0,
                       right_drive: 1'b0, auto_mix: 1'b1, error_latch: 1'b0,
                       jog_held: 1'b0, impulse_prev: 1'b0, since_end_hit: '0,
                       since_turn_on: '0, since_impulse: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_drives_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.left_drive && state_ff.right_drive))
      else $error("Both travel drives are on.");

   a_no_run_in_error: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.run_flag && state_ff.error_latch))
      else $error("Mixer runs while the stall error is latched.");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("Accepted transaction produced no result.");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("Controller state changed without a transaction.");

endmodule

/* sim/mixer_traverse_controller_tb.sv */
// Self-checking testbench that drives ticks and commands and predicts every result.
module mixer_traverse_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtc_pkg::*;

   localparam logic [2:0] OP_RESERVED = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int PLAN_LEN = 33;

   typedef struct packed {
      logic        cfg;
      reg_type     rsel;
      logic [15:0] wval;
      logic [2:0]  op;
      logic        dry;
      logic        ln;
      logic        rn;
      logic        imp;
      logic        pinned;
      logic [7:0]  want;
   } plan_row_type;

   typedef struct packed {
      logic       pinned;
      logic [7:0] outs;
   } typed_outputs_type;

   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{0, REG_DWELL_HM, 0, OP_RESERVED,    0, 1, 1, 0, 1, 8'h40},
      '{0, REG_DWELL_HM, 0, OP_JOG_L_PRESS, 0, 0, 1, 0, 1, 8'h40},
      '{0, REG_DWELL_HM, 0, OP_JOG_R_PRESS, 0, 1, 0, 0, 1, 8'h40},
      '{0, REG_DWELL_HM, 0, OP_JOG_L_PRESS, 0, 1, 1, 0, 1, 8'h01},
      '{0, REG_DWELL_HM, 0, OP_JOG_R_PRESS, 0, 1, 1, 0, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_TICK,        0, 1, 1, 0, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_JOG_L_REL,   0, 1, 1, 0, 1, 8'h40},
      '{0, REG_DWELL_HM, 0, OP_MIX_TOGGLE,  0, 1, 1, 0, 1, 8'h40},
      '{0, REG_DWELL_HM, 0, OP_MIX_TOGGLE,  1, 1, 1, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_SHUTDOWN,    1, 0, 0, 1, 0, 8'h00},
      '{1, REG_START_DELAY,   0, OP_TICK,   0, 1, 1, 0, 0, 8'h00},
      '{1, REG_DEFAULT_DWELL, 0, OP_TICK,   0, 1, 1, 0, 0, 8'h00},
      '{1, REG_IMP_TIMEOUT,   0, OP_TICK,   0, 1, 1, 0, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_JOG_R_PRESS, 0, 1, 1, 0, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_TICK,        0, 1, 1, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_TICK,        0, 1, 1, 1, 1, 8'h2C},
      '{0, REG_DWELL_HM, 0, OP_TICK,        0, 1, 0, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_JOG_R_PRESS, 0, 1, 1, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_JOG_R_REL,   0, 1, 1, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_JOG_L_PRESS, 0, 1, 1, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_JOG_L_REL,   0, 1, 1, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_MIX_TOGGLE,  0, 1, 1, 1, 1, 8'h40},
      '{0, REG_DWELL_HM, 0, OP_MIX_TOGGLE,  0, 1, 1, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_TICK,        1, 1, 1, 0, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_TICK,        1, 1, 0, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_TICK,        1, 1, 1, 0, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_TICK,        1, 0, 1, 1, 0, 8'h00},
      '{1, REG_DWELL_HM,      255,   OP_TICK, 0, 1, 1, 0, 0, 8'h00},
      '{1, REG_DEFAULT_DWELL, 65535, OP_TICK, 0, 1, 1, 0, 0, 8'h00},
      '{1, REG_START_DELAY,   65535, OP_TICK, 0, 1, 1, 0, 0, 8'h00},
      '{1, REG_IMP_TIMEOUT,   65535, OP_TICK, 0, 1, 1, 0, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_TICK,        1, 1, 1, 1, 0, 8'h00},
      '{0, REG_DWELL_HM, 0, OP_RESERVED,    1, 0, 0, 1, 0, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [7:0]  c_hm = 8'd0;
   logic [15:0] c_def = 16'd5000;
   logic [15:0] c_delay = 16'd2000;
   logic [15:0] c_tmo = 16'd2000;

   dir_type     trav = DIR_NONE;
   logic        mix_on = 1'b0;
   logic        drv_l = 1'b0;
   logic        drv_r = 1'b0;
   logic        auto_en = 1'b1;
   logic        stalled = 1'b0;
   logic        jog = 1'b0;
   logic        imp_last = 1'b0;
   logic [22:0] t_end = '0;
   logic [15:0] t_on = '0;
   logic [15:0] t_imp = '0;

   logic [7:0]        outputs_due [$];
   typed_outputs_type typed_due [$];
   logic [7:0]        due_outs;
   typed_outputs_type typed_now;
   int                mismatches = 0;
   int unsigned       cycles = 0;
   int                hold_left = 0;
   logic              calm = 1'b0;
   int                end_mode = 0;
   logic              imp_now = 1'b0;

   mixer_traverse_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic void mixer_switch(input logic on);
      if (stalled) begin
         mix_on = 1'b0;
         drv_l = 1'b0;
         drv_r = 1'b0;
      end else if (on) begin
         mix_on = 1'b1;
         t_on = '0;
         t_imp = '0;
      end else begin
         mix_on = 1'b0;
      end
   endfunction

   function automatic void traverse_step(input logic lp, input logic rp);
      if (c_delay <= t_on) begin
         if (trav == DIR_LEFT && !lp) begin
            drv_r = 1'b0;
            drv_l = 1'b1;
         end else if (trav == DIR_RIGHT && !rp) begin
            drv_l = 1'b0;
            drv_r = 1'b1;
         end
      end
   endfunction

   function automatic void dwell_step();
      logic [31:0] dwell;
      dwell = (c_hm == 8'd0) ? 32'(c_def) : c_hm * HALF_MINUTE_MS;
      if (auto_en && !stalled && dwell < 32'(t_end)) begin
         if (!mix_on) mixer_switch(1'b1);
         if (trav == DIR_HIT_RIGHT) trav = DIR_LEFT;
         else if (trav == DIR_HIT_LEFT || trav == DIR_NONE) trav = DIR_RIGHT;
      end
   endfunction

   function automatic void end_step(input logic lp, input logic rp);
      if (lp && trav == DIR_LEFT) begin
         drv_l = 1'b0;
         t_end = '0;
         trav = DIR_HIT_LEFT;
         if (!jog && !stalled && c_hm != 8'd0) mixer_switch(1'b0);
      end
      if (rp && trav == DIR_RIGHT) begin
         drv_r = 1'b0;
         t_end = '0;
         trav = DIR_HIT_RIGHT;
         if (!jog && !stalled && c_hm != 8'd0) mixer_switch(1'b0);
      end
   endfunction

   function automatic void watch_step(input logic lvl);
      if (mix_on) begin
         if (lvl != imp_last) begin
            imp_last = lvl;
            t_imp = '0;
         end
         if (c_tmo < t_imp) begin
            mixer_switch(1'b0);
            stalled = 1'b1;
         end
      end
   endfunction

   function automatic logic [7:0] controller_update(input logic [7:0] req);
      logic [2:0] op;
      logic       dry;
      logic       lp;
      logic       rp;
      logic       lvl;
      op = req[2:0];
      dry = req[3];
      lp = ~req[4];
      rp = ~req[5];
      lvl = req[6];
      case (op) inside
         OP_TICK: begin
            if (t_end != '1) t_end = t_end + 23'd1;
            if (t_on != '1) t_on = t_on + 16'd1;
            if (t_imp != '1) t_imp = t_imp + 16'd1;
            if (dry) begin
               dwell_step();
               traverse_step(lp, rp);
            end
            if (jog && !stalled) traverse_step(lp, rp);
            end_step(lp, rp);
            watch_step(lvl);
         end
         OP_JOG_L_PRESS, OP_JOG_R_PRESS: begin
            if (!((op == OP_JOG_L_PRESS) ? lp : rp) && !jog) begin
               mixer_switch(1'b1);
               trav = (op == OP_JOG_L_PRESS) ? DIR_LEFT : DIR_RIGHT;
               jog = 1'b1;
            end
         end
         OP_JOG_L_REL, OP_JOG_R_REL: begin
            if (op == OP_JOG_L_REL) drv_l = 1'b0;
            else drv_r = 1'b0;
            trav = DIR_NONE;
            mixer_switch(1'b0);
            jog = 1'b0;
         end
         OP_MIX_TOGGLE: begin
            if (stalled || auto_en) begin
               stalled = 1'b0;
               auto_en = 1'b0;
               mixer_switch(1'b0);
               drv_l = 1'b0;
               drv_r = 1'b0;
               trav = DIR_NONE;
            end else begin
               auto_en = 1'b1;
            end
         end
         OP_SHUTDOWN: begin
            mixer_switch(1'b0);
            drv_l = 1'b0;
            drv_r = 1'b0;
            mix_on = 1'b0;
         end
         default: begin
         end
      endcase
      return {1'b0, trav, stalled, drv_r, drv_l, mix_on};
   endfunction

   function automatic logic [7:0] pack_req(input logic [2:0] op, input logic dry,
                                           input logic ln, input logic rn, input logic imp);
      return {1'b0, imp, rn, ln, dry, op};
   endfunction

   function automatic logic [15:0] pick_window(input int small_max);
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16'($urandom_range(0, small_max));
      else if (r == 7) return 16'd0;
      else if (r == 8) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (outputs_due.size() == 0) begin
               $display("%0t ns: transaction %h arrived with nothing outstanding",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               due_outs = outputs_due.pop_front();
               check_field("mixer_run", 3'(due_outs[0]), 3'(rsp_tdata[0]));
               check_field("drive_left", 3'(due_outs[1]), 3'(rsp_tdata[1]));
               check_field("drive_right", 3'(due_outs[2]), 3'(rsp_tdata[2]));
               check_field("stall_error", 3'(due_outs[3]), 3'(rsp_tdata[3]));
               check_field("travel_state", due_outs[6:4], rsp_tdata[6:4]);
            end
         end
         if (req_tvalid && req_tready) begin
            typed_now = typed_due.pop_front();
            due_outs = controller_update(req_tdata);
            outputs_due.push_back(typed_now.pinned ? typed_now.outs : due_outs);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         hold_left <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d results outstanding", $time, outputs_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic offer(input logic [7:0] req, input logic pinned, input logic [7:0] outs);
      typed_due.push_back('{pinned, outs});
      req_tvalid <= 1'b1;
      req_tdata <= req;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outputs_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic reg_write(input reg_type rsel, input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {rsel, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (rsel)
         REG_DWELL_HM:      c_hm = value[7:0];
         REG_DEFAULT_DWELL: c_def = value;
         REG_START_DELAY:   c_delay = value;
         REG_IMP_TIMEOUT:   c_tmo = value;
         default: begin
         end
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {16'd0, value}) begin
         $display("%0t ns: register %0d read expected %h, actual %h",
                  $time, rsel, {16'd0, value}, csr_prdata);
         mismatches++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_settings();
      int r;
      settle();
      r = $urandom_range(0, 9);
      if (r < 6) reg_write(REG_DWELL_HM, 16'd0);
      else if (r < 8) reg_write(REG_DWELL_HM, 16'($urandom_range(1, 3)));
      else if (r == 8) reg_write(REG_DWELL_HM, 16'd255);
      else reg_write(REG_DWELL_HM, 16'($urandom_range(0, 255)));
      reg_write(REG_DEFAULT_DWELL, pick_window(40));
      reg_write(REG_START_DELAY, pick_window(20));
      reg_write(REG_IMP_TIMEOUT, pick_window(40));
   endtask

   task automatic random_run(input int count);
      int         r;
      logic [2:0] op;
      logic       dry;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 84) op = OP_TICK;
         else if (r < 88) op = $urandom_range(0, 1) ? OP_JOG_L_PRESS : OP_JOG_R_PRESS;
         else if (r < 92) op = $urandom_range(0, 1) ? OP_JOG_L_REL : OP_JOG_R_REL;
         else if (r < 96) op = OP_MIX_TOGGLE;
         else if (r < 98) op = OP_SHUTDOWN;
         else op = OP_RESERVED;
         dry = ($urandom_range(0, 9) != 0);
         if ($urandom_range(0, 7) == 0) end_mode = $urandom_range(0, 6);
         if ($urandom_range(0, 3) != 0) imp_now = ~imp_now;
         if (!calm && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         offer(pack_req(op, dry, !(end_mode == 4 || end_mode == 6),
                        !(end_mode == 5 || end_mode == 6), imp_now), 1'b0, 8'h00);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 4'h0;
      csr_pwdata = 32'h0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (PLAN[i]) begin
         if (PLAN[i].cfg) begin
            settle();
            reg_write(PLAN[i].rsel, PLAN[i].wval);
         end else begin
            offer(pack_req(PLAN[i].op, PLAN[i].dry, PLAN[i].ln, PLAN[i].rn, PLAN[i].imp),
                  PLAN[i].pinned, PLAN[i].want);
         end
      end

      for (int ph = 0; ph < 7; ph++) begin
         random_settings();
         random_run(230);
      end

      // Steady ticks with a half-minute dwell and the watchdog at its maximum.
      settle();
      calm <= 1'b1;
      while (!(auto_en && !stalled)) begin
         offer(pack_req(OP_MIX_TOGGLE, 1'b0, 1'b1, 1'b1, 1'b0), 1'b0, 8'h00);
         settle();
      end
      reg_write(REG_DWELL_HM, 16'd1);
      reg_write(REG_DEFAULT_DWELL, 16'd0);
      reg_write(REG_START_DELAY, 16'd10);
      reg_write(REG_IMP_TIMEOUT, 16'hFFFF);
      for (int k = 0; k < 60; k++) begin
         offer(pack_req(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b0), 1'b0, 8'h00);
      end
      for (int k = 0; k < 20; k++) begin
         offer(pack_req(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0, 8'h00);
      end

      random_settings();
      random_run(150);
      settle();
      repeat (4) @(posedge clock);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
